// ===== src/co2fr_pkg.sv =====
// ----------------------------------------------------------------------------
// co2fr_pkg
// Types and constants shared by the CO2 sensor frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package co2fr_pkg;

  localparam int FRAME_BYTES = 9;

  localparam logic [7:0]        START_BYTE   = 8'hFF;
  localparam logic [8:0]        TEMP_OFFSET  = 9'd44;
  localparam logic [15:0]       PPM_MIN      = 16'd400;
  localparam logic [15:0]       PPM_EXCLUDED = 16'd500;
  localparam logic signed [8:0] TEMP_MIN     = -9'sd30;

  // Configuration register indexes
  localparam logic REG_JUMP_LIMIT      = 1'b0;
  localparam logic REG_FILTER_STRENGTH = 1'b1;

  localparam logic [15:0] JUMP_LIMIT_RESET      = 16'd200;
  localparam logic [3:0]  FILTER_STRENGTH_RESET = 4'd2;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_NO_RESPONSE = 3'd1,
    STATUS_INCOMPLETE  = 3'd2,
    STATUS_CHECKSUM    = 3'd3,
    STATUS_INVALID     = 3'd4
  } status_t;

  // One classified frame or timeout, as passed from parser to filter
  typedef struct packed {
    status_t            status;
    logic [15:0]        ppm;
    logic signed [8:0]  temperature;
    logic [7:0]         sensor_status;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

endpackage

`default_nettype wire

// ===== src/co2fr_front.sv =====
// ----------------------------------------------------------------------------
// co2fr_front
// Frame parser: hunts for the start byte, collects the frame, checks the
// checksum and classifies the reading or the timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fr_front import co2fr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic        action,
  input  wire logic [7:0]  rx_byte,
  output push_t            push
);

  logic [3:0] byte_position, byte_position_next;
  logic       any_byte_seen, any_byte_seen_next;
  logic [7:0] sum_accum, sum_accum_next;
  logic [7:0] frame_store [4];
  logic       store_we;
  logic [1:0] store_idx;

  logic [15:0]       frame_ppm;
  logic signed [8:0] frame_temp;
  logic              checksum_ok;
  logic              reading_ok;

  assign store_idx  = byte_position[1:0] - 2'd2;
  assign frame_ppm  = {frame_store[0], frame_store[1]};
  assign frame_temp = $signed({1'b0, frame_store[2]} - TEMP_OFFSET);
  assign checksum_ok = ((8'd0 - sum_accum) == rx_byte);
  assign reading_ok = (frame_ppm > PPM_MIN) && (frame_ppm != PPM_EXCLUDED) &&
                      (frame_temp > TEMP_MIN) && (frame_store[3] == 8'd0);

  always_comb begin
    byte_position_next = byte_position;
    any_byte_seen_next = any_byte_seen;
    sum_accum_next     = sum_accum;
    store_we           = 1'b0;
    push               = '0;
    push.rec.status    = STATUS_OK;
    if (accept) begin
      if (action) begin
        push.valid         = 1'b1;
        push.rec.status    = any_byte_seen ? STATUS_INCOMPLETE : STATUS_NO_RESPONSE;
        byte_position_next = 4'd0;
        any_byte_seen_next = 1'b0;
        sum_accum_next     = 8'd0;
      end else begin
        any_byte_seen_next = 1'b1;
        if (byte_position == 4'd0 || byte_position >= 4'(FRAME_BYTES)) begin
          // hunting: only a start byte opens a frame
          byte_position_next = (rx_byte == START_BYTE) ? 4'd1 : 4'd0;
          sum_accum_next     = 8'd0;
        end else if (byte_position < 4'(FRAME_BYTES - 1)) begin
          sum_accum_next     = sum_accum + rx_byte;
          store_we           = (byte_position >= 4'd2) && (byte_position <= 4'd5);
          byte_position_next = byte_position + 4'd1;
        end else begin
          push.valid = 1'b1;
          if (!checksum_ok) begin
            push.rec.status = STATUS_CHECKSUM;
          end else begin
            push.rec.status        = reading_ok ? STATUS_OK : STATUS_INVALID;
            push.rec.ppm           = frame_ppm;
            push.rec.temperature   = frame_temp;
            push.rec.sensor_status = frame_store[3];
          end
          byte_position_next = 4'd0;
          any_byte_seen_next = 1'b0;
          sum_accum_next     = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 4'd0;
      any_byte_seen <= 1'b0;
      sum_accum     <= 8'd0;
    end else begin
      byte_position <= byte_position_next;
      any_byte_seen <= any_byte_seen_next;
      sum_accum     <= sum_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store[store_idx] <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== src/co2fr_queue.sv =====
// ----------------------------------------------------------------------------
// co2fr_queue
// Two-entry queue of classified records between parser and filter.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fr_queue import co2fr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire logic  pop,
  output rec_t       head,
  output logic       not_empty,
  output logic       full
);

  rec_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.rec;
    end
  end

endmodule

`default_nettype wire

// ===== src/co2fr_back.sv =====
// ----------------------------------------------------------------------------
// co2fr_back
// Smoothing filter and output register: takes one record a cycle from the
// queue when the output is not stalled, updates the filter on good readings and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fr_back import co2fr_pkg::*; #(
  parameter int FILTER_FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire rec_t        head,
  input  wire logic        q_not_empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rec_t             out_rec,
  output logic [15:0]      out_filtered
);

  localparam int ACC_W = 16 + FILTER_FRAC_BITS;

  logic [15:0]      jump_limit;
  logic [3:0]       filter_strength;
  logic [ACC_W-1:0] filter_accum, filter_accum_next;

  logic [ACC_W-1:0]        target;
  logic signed [17:0]      lag_diff;
  logic signed [17:0]      lag_limit;
  logic                    restart;
  logic signed [ACC_W:0]   step;
  logic signed [ACC_W:0]   step_shifted;
  logic [ACC_W-1:0]        smoothed;

  assign pop = q_not_empty && (!out_valid || out_ready);

  assign target    = {head.ppm, {FILTER_FRAC_BITS{1'b0}}};
  assign lag_diff  = $signed({2'b00, filter_accum[ACC_W-1:FILTER_FRAC_BITS]}) -
                     $signed({2'b00, head.ppm});
  assign lag_limit = $signed({2'b00, jump_limit});
  assign restart   = (filter_accum == '0) || (lag_diff > lag_limit) ||
                     (lag_diff < -lag_limit);
  // floor shift of the step toward the target
  assign step         = $signed({1'b0, target}) - $signed({1'b0, filter_accum});
  assign step_shifted = step >>> filter_strength;
  assign smoothed     = filter_accum + step_shifted[ACC_W-1:0];

  always_comb begin
    filter_accum_next = filter_accum;
    if (pop && head.status == STATUS_OK) begin
      filter_accum_next = restart ? target : smoothed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit      <= JUMP_LIMIT_RESET;
      filter_strength <= FILTER_STRENGTH_RESET;
      filter_accum    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_JUMP_LIMIT:      jump_limit      <= cfg_data;
          REG_FILTER_STRENGTH: filter_strength <= cfg_data[3:0];
          default:             jump_limit      <= jump_limit;
        endcase
      end
      filter_accum <= filter_accum_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec      <= head;
      out_filtered <= filter_accum_next[FILTER_FRAC_BITS +: 16];
    end
  end

endmodule

`default_nettype wire

// ===== src/co2_sensor_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// co2_sensor_frame_receiver
// Parses 9-byte CO2 sensor reply frames and smooths valid readings.
// ----------------------------------------------------------------------------
// Takes one beat per clock: tuser 0 carries a received byte, tuser 1 marks a
// response timeout. A complete frame or a timeout gives one result beat;
// other bytes give none. The parser classifies each beat in the cycle it is
// taken and writes a record into a two-entry queue; the filter unit takes one
// record a cycle from there while the output is not stalled and registers
// it as the result beat; up to one result per cycle is sustained. Input
// stalls only while the queue is full, which takes a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module co2_sensor_frame_receiver import co2fr_pkg::*; #(
  parameter int FILTER_FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [15:0] ppm, [24:16] temperature,
                                      // [32:25] sensor_status,
                                      // [48:33] filtered_ppm, rest zero
  output logic [2:0]       m_tuser    // [2:0] frame_status
);

  push_t       push;
  rec_t        head;
  rec_t        out_rec;
  logic        q_not_empty;
  logic        q_full;
  logic        pop;
  logic [15:0] out_filtered;
  logic        accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  co2fr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .action  (s_tuser),
    .rx_byte (s_tdata),
    .push    (push)
  );

  co2fr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  co2fr_back #(
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .q_not_empty  (q_not_empty),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_rec      (out_rec),
    .out_filtered (out_filtered)
  );

  assign m_tuser = out_rec.status;
  assign m_tdata = {7'd0, out_filtered, out_rec.sensor_status,
                    out_rec.temperature, out_rec.ppm};

endmodule

`default_nettype wire

// ===== src/co2fr_checker.sv =====
// ----------------------------------------------------------------------------
// co2fr_checker
// Port-level checks on the CO2 sensor frame receiver result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fr_checker import co2fr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // hold a stalled result beat
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("result offered straight after reset");

  // failed frames and timeouts carry no reading
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_NO_RESPONSE || m_tuser == STATUS_INCOMPLETE ||
                 m_tuser == STATUS_CHECKSUM)
    |-> m_tdata[32:0] == 33'd0)
    else $error("reading fields set on a failed frame");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_OK
    |-> m_tdata[15:0] > PPM_MIN && m_tdata[15:0] != PPM_EXCLUDED &&
        m_tdata[32:25] == 8'd0)
    else $error("good status on a reading that fails the checks");

endmodule

bind co2_sensor_frame_receiver co2fr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/tb_co2_sensor_frame_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_co2_sensor_frame_receiver
// Self-checking bench for the CO2 sensor frame receiver. Serial bytes and
// response timeouts go in as stream beats. An in-bench model of the frame
// parser and smoothing filter predicts every result beat, and each result is
// compared field by field. Traffic is mostly well-formed replies with random
// readings, mixed with line noise, cut-off replies, bad checksums and
// timeouts. It runs over several filter settings, with random gaps on the
// input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_co2_sensor_frame_receiver;
  import co2fr_pkg::*;

  localparam int          FRAC_BITS       = 8;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          SETTLE_CYCLES   = 6;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          PHASE_ITEMS     = 72;
  localparam logic [7:0]  CMD_READ        = 8'h86;

  typedef struct {
    status_t            status;
    logic [15:0]        ppm;
    logic signed [8:0]  temperature;
    logic [7:0]         sensor_status;
    logic [15:0]        filtered_ppm;
  } reading_t;

  typedef struct packed {
    logic       timeout;
    logic [7:0] rx;
  } serial_item_t;

  // Parser and filter model plus the readings still owed by the block
  class reading_predictor;
    logic [15:0]  lag_limit    = JUMP_LIMIT_RESET;
    logic [3:0]   smooth_shift = FILTER_STRENGTH_RESET;
    int unsigned  position     = 0;
    bit           byte_seen    = 1'b0;
    logic [7:0]   running_sum  = '0;
    logic [7:0]   payload [4];
    longint       smoothed     = 0;
    reading_t     readings_due [$];
    int unsigned  mismatches   = 0;
    int unsigned  status_seen [5];

    function void configure(logic idx, logic [15:0] value);
      if (idx == REG_JUMP_LIMIT)
        lag_limit = value;
      else
        smooth_shift = value[3:0];
    endfunction

    function void restart_hunt();
      position    = 0;
      byte_seen   = 1'b0;
      running_sum = '0;
    endfunction

    function void smooth(logic [15:0] ppm);
      longint target;
      longint jump;
      target = longint'(ppm) <<< FRAC_BITS;
      jump   = (smoothed >>> FRAC_BITS) - longint'(ppm);
      if (smoothed == 0 || jump > longint'(lag_limit) || jump < -longint'(lag_limit))
        smoothed = target;
      // arithmetic shift rounds towards minus infinity
      smoothed = smoothed + ((target - smoothed) >>> smooth_shift);
    endfunction

    function void note_beat(logic timeout, logic [7:0] rx);
      reading_t   r;
      int         t;
      logic [7:0] want_sum;
      r.ppm           = '0;
      r.temperature   = '0;
      r.sensor_status = '0;
      if (timeout) begin
        r.status = byte_seen ? STATUS_INCOMPLETE : STATUS_NO_RESPONSE;
      end else begin
        byte_seen = 1'b1;
        if (position == 0 || position >= FRAME_BYTES) begin
          position    = (rx == START_BYTE) ? 1 : 0;
          running_sum = '0;
          return;
        end
        if (position < FRAME_BYTES - 1) begin
          running_sum += rx;
          if (position >= 2 && position <= 5)
            payload[position - 2] = rx;
          position++;
          return;
        end
        want_sum = 8'h00 - running_sum;
        if (want_sum != rx) begin
          r.status = STATUS_CHECKSUM;
        end else begin
          t               = int'(payload[2]) - int'(TEMP_OFFSET);
          r.ppm           = {payload[0], payload[1]};
          r.temperature   = t[8:0];
          r.sensor_status = payload[3];
          if (r.ppm > PPM_MIN && r.ppm != PPM_EXCLUDED && t > TEMP_MIN && payload[3] == 0) begin
            r.status = STATUS_OK;
            smooth(r.ppm);
          end else begin
            r.status = STATUS_INVALID;
          end
        end
      end
      restart_hunt();
      r.filtered_ppm = 16'(smoothed >>> FRAC_BITS);
      readings_due.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reading(logic [2:0] status, logic [55:0] data);
      reading_t r;
      if (readings_due.size() == 0) begin
        $error("result beat with none due: status %0d, data %h", status, data);
        mismatches++;
        return;
      end
      r = readings_due.pop_front();
      status_seen[int'(r.status)]++;
      compare_field("frame_status", int'(r.status), status);
      compare_field("ppm", r.ppm, data[15:0]);
      compare_field("temperature", r.temperature, $signed(data[24:16]));
      compare_field("sensor_status", r.sensor_status, data[32:25]);
      compare_field("filtered_ppm", r.filtered_ppm, data[48:33]);
      compare_field("padding", 0, data[55:49]);
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
  logic        s_tuser   = 1'b0; // [0] action
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [55:0] m_tdata;          // [15:0] ppm, [24:16] temperature,
                                 // [32:25] sensor_status, [48:33] filtered_ppm
  logic [2:0]  m_tuser;          // [2:0] frame_status

  reading_predictor sb = new();
  serial_item_t     tx_q [$];
  int unsigned      items_queued = 0;
  int unsigned      beats_in     = 0;
  int unsigned      beats_out    = 0;
  bit               hold_request = 1'b0;
  logic [15:0]      ppm_level    = 16'd800;

  co2_sensor_frame_receiver i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic queue_item(logic timeout, logic [7:0] rx);
    serial_item_t item;
    item.timeout = timeout;
    item.rx      = rx;
    tx_q.push_back(item);
    items_queued++;
  endtask

  task automatic queue_frame(logic [15:0] ppm, logic [7:0] temp_raw,
                             logic [7:0] status_raw, bit corrupt);
    logic [7:0] body [1:7];
    logic [7:0] sum;
    body[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : CMD_READ;
    body[2] = ppm[15:8];
    body[3] = ppm[7:0];
    body[4] = temp_raw;
    body[5] = status_raw;
    body[6] = 8'($urandom);
    body[7] = 8'($urandom);
    sum = '0;
    for (int i = 1; i <= 7; i++)
      sum += body[i];
    queue_item(1'b0, START_BYTE);
    for (int i = 1; i <= 7; i++)
      queue_item(1'b0, body[i]);
    if (corrupt)
      queue_item(1'b0, (8'h00 - sum) ^ 8'($urandom_range(1, 255)));
    else
      queue_item(1'b0, 8'h00 - sum);
  endtask

  task automatic queue_random_frame();
    logic [15:0] ppm;
    logic [7:0]  temp_raw;
    logic [7:0]  status_raw;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      ppm = 16'(ppm_level + $urandom_range(0, 40) - 20);
    end else if (pick < 75) begin
      ppm = 16'(ppm_level + $urandom_range(0, 1200) - 600);
    end else if (pick < 90) begin
      case ($urandom_range(0, 6))
        0:       ppm = PPM_MIN;
        1:       ppm = PPM_MIN + 16'd1;
        2:       ppm = PPM_EXCLUDED - 16'd1;
        3:       ppm = PPM_EXCLUDED;
        4:       ppm = PPM_EXCLUDED + 16'd1;
        5:       ppm = 16'h0000;
        default: ppm = 16'hFFFF;
      endcase
    end else begin
      ppm = 16'($urandom);
    end
    // drift the level so the filter sees both small steps and restarts
    if (pick < 75 && ppm > PPM_MIN && ppm < 16'd20000)
      ppm_level = ppm;
    case ($urandom_range(0, 9))
      7:       temp_raw = 8'($urandom_range(13, 16));
      8, 9:    temp_raw = 8'($urandom);
      default: temp_raw = 8'($urandom_range(50, 90));
    endcase
    status_raw = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    queue_frame(ppm, temp_raw, status_raw, $urandom_range(0, 9) == 0);
  endtask

  task automatic queue_random_traffic(int unsigned count);
    int unsigned start;
    int          kind;
    int          n;
    start = items_queued;
    while (items_queued - start < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        queue_random_frame();
      end else if (kind < 75) begin
        // line noise while hunting
        n = $urandom_range(1, 4);
        repeat (n) queue_item(1'b0, 8'($urandom_range(0, 254)));
      end else if (kind < 85) begin
        // reply cut off by the response window
        queue_item(1'b0, START_BYTE);
        n = $urandom_range(0, 7);
        repeat (n) queue_item(1'b0, 8'($urandom));
        queue_item(1'b1, 8'($urandom));
      end else if (kind < 95) begin
        queue_item(1'b1, 8'($urandom));
      end else begin
        queue_item(1'b0, 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.configure(idx, value);
  endtask

  // Hold until every byte is taken and every reading is back, then settle
  task automatic wait_idle();
    @(posedge clk);
    while (beats_in != items_queued || sb.readings_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : sender
    serial_item_t item;
    int           burst_left;
    int           gap_left;
    burst_left = 1;
    gap_left   = 0;
    forever begin
      @(posedge clk);
      if (s_tvalid && s_tready) begin
        sb.note_beat(s_tuser, s_tdata);
        beats_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (tx_q.size() > 0) begin
          item = tx_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= item.timeout;
          s_tdata  <= item.rx;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  initial begin : receiver
    logic [15:0] pattern;
    int unsigned pattern_bit;
    int unsigned pattern_left;
    int unsigned hold_left;
    pattern      = '1;
    pattern_bit  = 0;
    pattern_left = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_reading(m_tuser, m_tdata);
        beats_out++;
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(50, 250);
          case ($urandom_range(0, 3))
            0:       pattern = '1;
            1:       pattern = 16'($urandom) | 16'h0001;
            2:       pattern = 16'($urandom) | 16'($urandom) | 16'h0001;
            default: pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
          endcase
        end
        pattern_left--;
        m_tready    <= pattern[pattern_bit];
        pattern_bit  = (pattern_bit + 1) % 16;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    int unsigned last_total;
    quiet      = 0;
    last_total = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (beats_in + beats_out != last_total) begin
        last_total = beats_in + beats_out;
        quiet      = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat moved for %0d cycles, %0d readings outstanding",
             WATCHDOG_LIMIT, sb.readings_due.size());
    $display("tb_co2_sensor_frame_receiver: errors");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // timeout straight after reset, then a stray byte and a timeout
    queue_item(1'b1, 8'h00);
    queue_item(1'b0, 8'h00);
    queue_item(1'b1, 8'hFF);
    // top-of-range reading with start-byte values inside the frame
    queue_frame(16'hFFFF, 8'hFF, 8'h00, 1'b0);
    // all-zero ppm and temperature bytes, status 0xFF, with a broken checksum
    queue_frame(16'h0000, 8'h00, 8'hFF, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_JUMP_LIMIT, 16'd0);
          write_reg(REG_FILTER_STRENGTH, 16'd0);
        end
        2: begin
          write_reg(REG_JUMP_LIMIT, 16'hFFFF);
          write_reg(REG_FILTER_STRENGTH, 16'd8);
        end
        3: begin
          write_reg(REG_JUMP_LIMIT, 16'd50);
          write_reg(REG_FILTER_STRENGTH, 16'd15);
        end
        4: begin
          write_reg(REG_JUMP_LIMIT, 16'($urandom_range(0, 1000)));
          write_reg(REG_FILTER_STRENGTH, 16'($urandom_range(0, 15)));
        end
        5: begin
          write_reg(REG_JUMP_LIMIT, JUMP_LIMIT_RESET);
          write_reg(REG_FILTER_STRENGTH, 16'd1);
        end
        default: ;
      endcase
      ppm_level = 16'($urandom_range(420, 3000));
      if (phase == 5) begin
        // stall the output for a long stretch so the block backs up its input
        hold_request = 1'b1;
        repeat (40) queue_item(1'b1, 8'($urandom));
      end
      queue_random_traffic(PHASE_ITEMS);
      wait_idle();
    end

    $display("run: %0d input beats, %0d results (ok %0d, no response %0d, incomplete %0d,",
             beats_in, beats_out, sb.status_seen[STATUS_OK],
             sb.status_seen[STATUS_NO_RESPONSE], sb.status_seen[STATUS_INCOMPLETE]);
    $display("run: checksum %0d, invalid %0d) over six filter settings incl. lag 0/65535",
             sb.status_seen[STATUS_CHECKSUM], sb.status_seen[STATUS_INVALID]);
    if (sb.mismatches == 0 && sb.readings_due.size() == 0)
      $display("tb_co2_sensor_frame_receiver: clean");
    else
      $display("tb_co2_sensor_frame_receiver: errors");
    $finish;
  end

endmodule
